// ===== rtl/ddpi_pkg.sv =====
// Shared types, constants and the arctangent table of the differential-drive pose integrator.
`default_nettype none

package ddpi_pkg;

  // Default number of rotation steps of the angle unit.
  localparam int CORDIC_STEPS_DEF = 24;

  // Shared multiplier operand and product widths.
  localparam int MUL_AW = 36;
  localparam int MUL_BW = 18;
  localparam int MUL_PW = MUL_AW + MUL_BW;

  // Width of the rotation vector and angle residual inside the angle unit.
  localparam int VEC_W = 34;

  // Starting x of the rotation, the limit gain constant in Q4.30.
  localparam logic signed [VEC_W-1:0] CORDIC_K = 34'sd652032874;

  // Register reset values.
  localparam logic [15:0] FILTER_ALPHA_RST  = 16'd62259;
  localparam logic [31:0] TURN_GAIN_RST     = 32'd6835652;
  localparam logic [31:0] MOVE_GAIN_RST     = 32'd2147484;
  localparam logic [15:0] REPORT_PERIOD_RST = 16'd20;

  typedef enum logic [1:0] {
    REG_FILTER_ALPHA  = 2'd0,
    REG_TURN_GAIN     = 2'd1,
    REG_MOVE_GAIN     = 2'd2,
    REG_REPORT_PERIOD = 2'd3
  } cfg_reg_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_L0,
    ST_L1,
    ST_R0,
    ST_R1,
    ST_RW,
    ST_T0,
    ST_T1,
    ST_M0,
    ST_M1,
    ST_MW,
    ST_CW,
    ST_X0,
    ST_X1,
    ST_Y0,
    ST_Y1,
    ST_YW,
    ST_EMIT
  } seq_state_t;

  // Arctangent of 2^-i in binary-angle units (full turn = 2^32).
  function automatic logic [29:0] atan_unit(input logic [4:0] idx);
    logic [29:0] r;
    case (idx)
      5'd0:  r = 30'd536870912;
      5'd1:  r = 30'd316933406;
      5'd2:  r = 30'd167458907;
      5'd3:  r = 30'd85004756;
      5'd4:  r = 30'd42667331;
      5'd5:  r = 30'd21354465;
      5'd6:  r = 30'd10679838;
      5'd7:  r = 30'd5340245;
      5'd8:  r = 30'd2670163;
      5'd9:  r = 30'd1335087;
      5'd10: r = 30'd667544;
      5'd11: r = 30'd333772;
      5'd12: r = 30'd166886;
      5'd13: r = 30'd83443;
      5'd14: r = 30'd41722;
      5'd15: r = 30'd20861;
      5'd16: r = 30'd10430;
      5'd17: r = 30'd5215;
      5'd18: r = 30'd2608;
      5'd19: r = 30'd1304;
      5'd20: r = 30'd652;
      5'd21: r = 30'd326;
      5'd22: r = 30'd163;
      5'd23: r = 30'd81;
      5'd24: r = 30'd41;
      5'd25: r = 30'd20;
      5'd26: r = 30'd10;
      5'd27: r = 30'd5;
      5'd28: r = 30'd3;
      5'd29: r = 30'd1;
      5'd30: r = 30'd1;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ddpi_mul.sv =====
// Shared signed multiplier with a registered product.
`default_nettype none

module ddpi_mul (
  input  wire logic                                 clk,
  input  wire logic signed [ddpi_pkg::MUL_AW-1:0]   a,
  input  wire logic signed [ddpi_pkg::MUL_BW-1:0]   b,
  output logic signed      [ddpi_pkg::MUL_PW-1:0]   p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

`default_nettype wire

// ===== rtl/ddpi_cordic.sv =====
// Rotation-mode angle unit: one rotation step per cycle, then quadrant map and clamp.
`default_nettype none

module ddpi_cordic #(
  parameter int CORDIC_STEPS = ddpi_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [31:0]        angle,
  output logic                    busy,
  output logic signed [31:0]      cos_v,
  output logic signed [31:0]      sin_v
);

  localparam int ITW = $clog2(CORDIC_STEPS + 1);
  localparam int VW  = ddpi_pkg::VEC_W;
  localparam logic signed [VW-1:0] Q30_ONE = VW'(64'sd1073741824);

  logic [ITW-1:0]        iter;
  logic [1:0]            quad;
  logic signed [VW-1:0]  rz;
  logic signed [VW-1:0]  vx;
  logic signed [VW-1:0]  vy;

  logic [31:0]           ang_rnd;
  logic [1:0]            start_quad;
  logic [31:0]           residual;
  logic [4:0]            idx;
  logic signed [VW-1:0]  sx;
  logic signed [VW-1:0]  sy;
  logic signed [VW-1:0]  atan_v;
  logic signed [VW-1:0]  map_c;
  logic signed [VW-1:0]  map_s;

  function automatic logic signed [31:0] clamp_q30(input logic signed [VW-1:0] v);
    logic signed [31:0] r;
    if (v > Q30_ONE) begin
      r = 32'sd1073741824;
    end else if (v < -Q30_ONE) begin
      r = -32'sd1073741824;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // The top two bits of the angle, rounded to the nearest quarter turn, pick
  // the quadrant; the rest is a signed residual within an eighth turn.
  assign ang_rnd    = angle + 32'h2000_0000;
  assign start_quad = ang_rnd[31:30];
  assign residual   = angle - {start_quad, 30'd0};

  assign idx    = 5'(iter);
  assign sx     = vx >>> idx;
  assign sy     = vy >>> idx;
  assign atan_v = $signed({{(VW-30){1'b0}}, ddpi_pkg::atan_unit(idx)});

  always_comb begin
    case (quad)
      2'd0: begin
        map_c = vx;
        map_s = vy;
      end
      2'd1: begin
        map_c = -vy;
        map_s = vx;
      end
      2'd2: begin
        map_c = -vx;
        map_s = -vy;
      end
      default: begin
        map_c = vy;
        map_s = -vx;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      iter <= '0;
    end else if (start) begin
      busy <= 1'b1;
      iter <= '0;
    end else if (busy) begin
      if (iter == ITW'(CORDIC_STEPS)) begin
        busy <= 1'b0;
      end else begin
        iter <= iter + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quad <= start_quad;
      rz   <= VW'($signed(residual));
      vx   <= ddpi_pkg::CORDIC_K;
      vy   <= '0;
    end else if (busy) begin
      if (iter != ITW'(CORDIC_STEPS)) begin
        if (!rz[VW-1]) begin
          vx <= vx - sy;
          vy <= vy + sx;
          rz <= rz - atan_v;
        end else begin
          vx <= vx + sy;
          vy <= vy - sx;
          rz <= rz + atan_v;
        end
      end else begin
        cos_v <= clamp_q30(map_c);
        sin_v <= clamp_q30(map_s);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/differential_drive_pose_integrator.sv =====
// Top level of the differential-drive pose integrator: sequencer, state and ports.
//
//  Channel | Dir | Handshake              | Contents
//  s_*     | in  | s_tvalid / s_tready    | one physics tick: left and right wheel drives
//  m_*     | out | m_tvalid / m_tready    | pose report: x, y, heading
//  cfg_*   | in  | cfg_we (no wait)       | register index and write data
//
// A tick runs from one accepted word to the next through a sequence of twelve products
// on the one shared multiplier, with the angle unit's rotation steps, one per cycle,
// covering most of the time.
// s_tready is high only between ticks. A finished report waits in the output
// register; the next tick is accepted meanwhile and only its own report, if
// any, waits for that register to empty. Reset is synchronous and clears the
// pose, lagged drives, report counter and registers to their defaults.
`default_nettype none

module differential_drive_pose_integrator #(
  parameter int CORDIC_STEPS = ddpi_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  // s_tdata: [15:0] desired_left, [31:16] desired_right
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [31:0]  s_tdata,
  // m_tdata: [47:0] pos_x, [95:48] pos_y, [127:96] heading
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [127:0]      m_tdata,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [31:0]  cfg_data
);

  localparam int AW = ddpi_pkg::MUL_AW;
  localparam int BW = ddpi_pkg::MUL_BW;
  localparam int PW = ddpi_pkg::MUL_PW;

  ddpi_pkg::seq_state_t state;
  ddpi_pkg::seq_state_t state_next;

  logic [15:0]         filter_alpha;
  logic [31:0]         turn_gain;
  logic [31:0]         move_gain;
  logic [15:0]         report_period;

  logic signed [15:0]  drive_l;
  logic signed [15:0]  drive_r;
  logic signed [31:0]  left_lagged;
  logic signed [31:0]  right_lagged;
  logic [31:0]         heading_acc;
  logic signed [47:0]  x_acc;
  logic signed [47:0]  y_acc;
  logic [15:0]         ticks_since_report;
  logic signed [35:0]  step_len;
  logic signed [63:0]  acc;
  logic                report;

  logic signed [AW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;
  logic signed [PW-1:0] mul_p;
  logic signed [63:0]   prod;

  logic                 cordic_busy;
  logic signed [31:0]   cos_v;
  logic signed [31:0]   sin_v;

  logic signed [32:0]   ddiff;
  logic signed [32:0]   dsum;
  logic [17:0]          alpha_c;
  logic signed [63:0]   lag_sum;
  logic signed [63:0]   turn_sum;
  logic signed [63:0]   step_sum;
  logic signed [63:0]   scale_sum;
  logic signed [49:0]   pos_sum;
  logic signed [47:0]   pos_sat;
  logic signed [47:0]   pos_base;
  logic [16:0]          tick_inc;
  logic                 out_free;
  logic                 emit_load;

  ddpi_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  ddpi_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (state == ddpi_pkg::ST_M1),
    .angle (heading_acc),
    .busy  (cordic_busy),
    .cos_v (cos_v),
    .sin_v (sin_v)
  );

  assign s_tready  = (state == ddpi_pkg::ST_IDLE);
  assign out_free  = !m_tvalid || m_tready;
  assign emit_load = (state == ddpi_pkg::ST_EMIT) && report && out_free;

  assign prod    = 64'(mul_p);
  assign ddiff   = 33'(left_lagged) - 33'(right_lagged);
  assign dsum    = 33'(left_lagged) + 33'(right_lagged);
  assign alpha_c = 18'h10000 - {2'b00, filter_alpha};

  // Each state consumes the product issued in the state before it.
  assign lag_sum   = acc + (prod <<< 16) + 64'sd32768;
  assign turn_sum  = acc + prod + 64'sd1073741824;
  assign step_sum  = acc + 64'sd16384 + (prod >>> 16);
  assign scale_sum = acc + 64'sd16384 + (prod >>> 15);
  assign pos_base  = (state == ddpi_pkg::ST_Y0) ? x_acc : y_acc;
  assign pos_sum   = 50'(pos_base) + 50'(scale_sum >>> 15);
  assign tick_inc  = {1'b0, ticks_since_report} + 17'd1;

  // Saturate to the 48-bit position range.
  always_comb begin
    if (pos_sum[49:47] == 3'b000 || pos_sum[49:47] == 3'b111) begin
      pos_sat = pos_sum[47:0];
    end else if (pos_sum[49]) begin
      pos_sat = {1'b1, 47'd0};
    end else begin
      pos_sat = {1'b0, {47{1'b1}}};
    end
  end

  // Multiplier operand selection.
  always_comb begin
    unique case (state)
      ddpi_pkg::ST_L0: begin
        mul_a = AW'(left_lagged);
        mul_b = $signed({2'b00, filter_alpha});
      end
      ddpi_pkg::ST_L1: begin
        mul_a = AW'(drive_l);
        mul_b = $signed(alpha_c);
      end
      ddpi_pkg::ST_R0: begin
        mul_a = AW'(right_lagged);
        mul_b = $signed({2'b00, filter_alpha});
      end
      ddpi_pkg::ST_R1: begin
        mul_a = AW'(drive_r);
        mul_b = $signed(alpha_c);
      end
      ddpi_pkg::ST_T0: begin
        mul_a = AW'(ddiff);
        mul_b = $signed({2'b00, turn_gain[31:16]});
      end
      ddpi_pkg::ST_T1: begin
        mul_a = AW'(ddiff);
        mul_b = $signed({2'b00, turn_gain[15:0]});
      end
      ddpi_pkg::ST_M0: begin
        mul_a = AW'(dsum);
        mul_b = $signed({2'b00, move_gain[31:16]});
      end
      ddpi_pkg::ST_M1: begin
        mul_a = AW'(dsum);
        mul_b = $signed({2'b00, move_gain[15:0]});
      end
      // The upper part of a factor is signed, so it is sign-extended.
      ddpi_pkg::ST_X0: begin
        mul_a = step_len;
        mul_b = {cos_v[31], cos_v[31:15]};
      end
      ddpi_pkg::ST_X1: begin
        mul_a = step_len;
        mul_b = $signed({3'b000, cos_v[14:0]});
      end
      ddpi_pkg::ST_Y0: begin
        mul_a = step_len;
        mul_b = {sin_v[31], sin_v[31:15]};
      end
      ddpi_pkg::ST_Y1: begin
        mul_a = step_len;
        mul_b = $signed({3'b000, sin_v[14:0]});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ddpi_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ddpi_pkg::ST_IDLE: if (s_tvalid) state_next = ddpi_pkg::ST_L0;
      ddpi_pkg::ST_L0:   state_next = ddpi_pkg::ST_L1;
      ddpi_pkg::ST_L1:   state_next = ddpi_pkg::ST_R0;
      ddpi_pkg::ST_R0:   state_next = ddpi_pkg::ST_R1;
      ddpi_pkg::ST_R1:   state_next = ddpi_pkg::ST_RW;
      ddpi_pkg::ST_RW:   state_next = ddpi_pkg::ST_T0;
      ddpi_pkg::ST_T0:   state_next = ddpi_pkg::ST_T1;
      ddpi_pkg::ST_T1:   state_next = ddpi_pkg::ST_M0;
      ddpi_pkg::ST_M0:   state_next = ddpi_pkg::ST_M1;
      ddpi_pkg::ST_M1:   state_next = ddpi_pkg::ST_MW;
      ddpi_pkg::ST_MW:   state_next = ddpi_pkg::ST_CW;
      ddpi_pkg::ST_CW:   if (!cordic_busy) state_next = ddpi_pkg::ST_X0;
      ddpi_pkg::ST_X0:   state_next = ddpi_pkg::ST_X1;
      ddpi_pkg::ST_X1:   state_next = ddpi_pkg::ST_Y0;
      ddpi_pkg::ST_Y0:   state_next = ddpi_pkg::ST_Y1;
      ddpi_pkg::ST_Y1:   state_next = ddpi_pkg::ST_YW;
      ddpi_pkg::ST_YW:   state_next = ddpi_pkg::ST_EMIT;
      ddpi_pkg::ST_EMIT: if (!report || out_free) state_next = ddpi_pkg::ST_IDLE;
      default:           state_next = ddpi_pkg::ST_IDLE;
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_alpha  <= ddpi_pkg::FILTER_ALPHA_RST;
      turn_gain     <= ddpi_pkg::TURN_GAIN_RST;
      move_gain     <= ddpi_pkg::MOVE_GAIN_RST;
      report_period <= ddpi_pkg::REPORT_PERIOD_RST;
    end else if (cfg_we) begin
      unique case (ddpi_pkg::cfg_reg_t'(cfg_index))
        ddpi_pkg::REG_FILTER_ALPHA:  filter_alpha  <= cfg_data[15:0];
        ddpi_pkg::REG_TURN_GAIN:     turn_gain     <= cfg_data;
        ddpi_pkg::REG_MOVE_GAIN:     move_gain     <= cfg_data;
        ddpi_pkg::REG_REPORT_PERIOD: report_period <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Pose state and report counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      left_lagged        <= '0;
      right_lagged       <= '0;
      heading_acc        <= '0;
      x_acc              <= '0;
      y_acc              <= '0;
      ticks_since_report <= '0;
      report             <= 1'b0;
    end else begin
      case (state)
        ddpi_pkg::ST_R0: left_lagged  <= lag_sum[47:16];
        ddpi_pkg::ST_RW: right_lagged <= lag_sum[47:16];
        ddpi_pkg::ST_M0: heading_acc  <= heading_acc + turn_sum[62:31];
        ddpi_pkg::ST_Y0: x_acc        <= pos_sat;
        ddpi_pkg::ST_YW: begin
          y_acc <= pos_sat;
          if (tick_inc >= {1'b0, report_period}) begin
            ticks_since_report <= '0;
            report             <= 1'b1;
          end else begin
            ticks_since_report <= tick_inc[15:0];
            report             <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Working registers of the sequence.
  always_ff @(posedge clk) begin
    if (state == ddpi_pkg::ST_IDLE && s_tvalid) begin
      drive_l <= $signed(s_tdata[15:0]);
      drive_r <= $signed(s_tdata[31:16]);
    end
    case (state)
      ddpi_pkg::ST_L1: acc      <= prod;
      ddpi_pkg::ST_R1: acc      <= prod;
      ddpi_pkg::ST_T1: acc      <= prod <<< 16;
      ddpi_pkg::ST_M1: acc      <= prod;
      ddpi_pkg::ST_MW: step_len <= step_sum[50:15];
      ddpi_pkg::ST_X1: acc      <= prod;
      ddpi_pkg::ST_Y1: acc      <= prod;
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      m_tdata <= {heading_acc, y_acc, x_acc};
    end
  end

endmodule

`default_nettype wire
